// ===== rtl/zst_pkg.sv =====
// Shared types and sizing constants for the zero-sum triple finder.
// Used by every module under rtl; depends on nothing.
package zst_pkg;

	localparam int CAPACITY    = 64;
	localparam int MAX_RESULTS = 64;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);
	localparam int SUM_W       = 18;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic signed [15:0] value;
		logic               final_item;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] first;
		logic signed [15:0] second;
		logic signed [15:0] third;
		logic               found;
		logic               last_result;
		logic               truncated;
		logic               inputs_dropped;
	} out_item_t;

	// Head of the queue between the front and the back.
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} q_head_t;

endpackage

// ===== rtl/zst_front.sv =====
// Front end: accepts input items and holds them in a short queue.
// Depends on zst_pkg.
module zst_front import zst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  in_item_t item,
	output q_head_t  head,
	input  logic     pop
);

	in_item_t            buf_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                take;

	assign item_stall = (count_q == QCNT_W'(QDEPTH));
	assign push       = item_valid && !item_stall;
	assign take       = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item  = buf_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (take) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("queue count past depth");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QCNT_W'(QDEPTH)) && !take |=> count_q == QCNT_W'(QDEPTH))
		else $error("full queue lost an item");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wptr_q == rptr_q)) else $error("empty queue pointers differ");

endmodule

// ===== rtl/zst_back.sv =====
// Back end: stores the set, sorts it in place and runs the two-pointer search.
// Depends on zst_pkg; takes items from the front's queue.
module zst_back import zst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_head_t   head,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	typedef enum logic [4:0] {
		S_LOAD, S_SSTART, S_SNEXT, S_SKEY, S_SKEY_EV, S_SRD, S_SEV,
		S_ANCH, S_ANCH_EV, S_PAIR_RD, S_PAIR_EV, S_LDUP, S_LDUP_EV,
		S_HDUP, S_HDUP_EV, S_ADUP, S_ADUP_EV, S_FIN
	} state_t;

	logic signed [15:0] mem [CAPACITY];
	logic signed [15:0] rd0_q, rd1_q;
	logic [IDX_W-1:0]   ra0, ra1, wa;
	logic signed [15:0] wd;
	logic               we;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q, i_q, j_q, a_q, lo_q, hi_q;
	logic               ovf_q;
	logic signed [15:0] key_q, aval_q;
	out_item_t          pend_q;
	logic               pend_v_q;
	logic [RES_W-1:0]   rcnt_q;
	out_item_t          out_q;
	logic               out_v_q;

	logic               ofree;
	logic signed [SUM_W-1:0] sum;
	logic [CNT_W-1:0]   lo_p1, hi_m1, a_p1, j_m1;

	assign ofree = !out_v_q || !res_stall;
	assign lo_p1 = lo_q + 1'b1;
	assign hi_m1 = hi_q - 1'b1;
	assign a_p1  = a_q + 1'b1;
	assign j_m1  = j_q - 1'b1;
	assign sum   = SUM_W'(aval_q) + SUM_W'(rd0_q) + SUM_W'(rd1_q);
	assign res_valid = out_v_q;
	assign res       = out_q;
	assign pop       = (state_q == S_LOAD) && head.valid;

	always_comb begin
		ra0 = lo_q[IDX_W-1:0];
		ra1 = hi_q[IDX_W-1:0];
		we  = 1'b0;
		wa  = cnt_q[IDX_W-1:0];
		wd  = head.item.value;
		case (state_q)
			S_LOAD: begin
				we = head.valid && (cnt_q < CNT_W'(CAPACITY));
			end
			S_SKEY: ra0 = i_q[IDX_W-1:0];
			S_SRD: begin
				ra0 = j_m1[IDX_W-1:0];
				if (j_q == '0) begin
					we = 1'b1;
					wa = '0;
					wd = key_q;
				end
			end
			S_SEV: begin
				we = 1'b1;
				wa = j_q[IDX_W-1:0];
				wd = (rd0_q > key_q) ? rd0_q : key_q;
			end
			S_ANCH:  ra0 = a_q[IDX_W-1:0];
			S_LDUP:  ra0 = lo_p1[IDX_W-1:0];
			S_HDUP:  ra1 = hi_m1[IDX_W-1:0];
			S_ADUP:  ra0 = a_p1[IDX_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			a_q      <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			key_q    <= '0;
			aval_q   <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			rcnt_q   <= '0;
			out_q    <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (ofree) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (head.valid) begin
						if (cnt_q < CNT_W'(CAPACITY)) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (head.item.final_item) begin
							state_q <= S_SSTART;
						end
					end
				end
				S_SSTART: begin
					i_q     <= CNT_W'(1);
					state_q <= S_SNEXT;
				end
				S_SNEXT: begin
					if (i_q < cnt_q) begin
						state_q <= S_SKEY;
					end else begin
						a_q     <= '0;
						state_q <= S_ANCH;
					end
				end
				S_SKEY: state_q <= S_SKEY_EV;
				S_SKEY_EV: begin
					key_q   <= rd0_q;
					j_q     <= i_q;
					state_q <= S_SRD;
				end
				S_SRD: begin
					if (j_q == '0) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SNEXT;
					end else begin
						state_q <= S_SEV;
					end
				end
				S_SEV: begin
					if (rd0_q > key_q) begin
						j_q     <= j_m1;
						state_q <= S_SRD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SNEXT;
					end
				end
				S_ANCH: begin
					state_q <= (a_q < cnt_q) ? S_ANCH_EV : S_FIN;
				end
				S_ANCH_EV: begin
					aval_q  <= rd0_q;
					lo_q    <= a_p1;
					hi_q    <= cnt_q - 1'b1;
					state_q <= S_PAIR_RD;
				end
				S_PAIR_RD: begin
					state_q <= (lo_q < hi_q) ? S_PAIR_EV : S_ADUP;
				end
				S_PAIR_EV: begin
					if (sum > 0) begin
						hi_q    <= hi_m1;
						state_q <= S_PAIR_RD;
					end else if (sum < 0) begin
						lo_q    <= lo_p1;
						state_q <= S_PAIR_RD;
					end else if (rcnt_q == RES_W'(MAX_RESULTS)) begin
						// One triple past the limit: close the set on the held one.
						if (ofree) begin
							out_v_q               <= 1'b1;
							out_q                 <= pend_q;
							out_q.last_result     <= 1'b1;
							out_q.truncated       <= 1'b1;
							out_q.inputs_dropped  <= ovf_q;
							cnt_q                 <= '0;
							ovf_q                 <= 1'b0;
							pend_v_q              <= 1'b0;
							rcnt_q                <= '0;
							state_q               <= S_LOAD;
						end
					end else if (ofree || !pend_v_q) begin
						// The newest triple is held back until we know whether it is the last.
						if (pend_v_q) begin
							out_v_q              <= 1'b1;
							out_q                <= pend_q;
							out_q.inputs_dropped <= ovf_q;
						end
						pend_q.first          <= aval_q;
						pend_q.second         <= rd0_q;
						pend_q.third          <= rd1_q;
						pend_q.found          <= 1'b1;
						pend_q.last_result    <= 1'b0;
						pend_q.truncated      <= 1'b0;
						pend_q.inputs_dropped <= 1'b0;
						pend_v_q              <= 1'b1;
						rcnt_q                <= rcnt_q + 1'b1;
						state_q               <= S_LDUP;
					end
				end
				S_LDUP: begin
					if (lo_p1 <= hi_q) begin
						state_q <= S_LDUP_EV;
					end else begin
						lo_q    <= lo_p1;
						state_q <= S_HDUP;
					end
				end
				S_LDUP_EV: begin
					lo_q    <= lo_p1;
					state_q <= (rd0_q == pend_q.second) ? S_LDUP : S_HDUP;
				end
				S_HDUP: begin
					if (hi_q > lo_q) begin
						state_q <= S_HDUP_EV;
					end else begin
						hi_q    <= hi_m1;
						state_q <= S_PAIR_RD;
					end
				end
				S_HDUP_EV: begin
					hi_q    <= hi_m1;
					state_q <= (rd1_q == pend_q.third) ? S_HDUP : S_PAIR_RD;
				end
				S_ADUP: begin
					if (a_p1 < cnt_q) begin
						state_q <= S_ADUP_EV;
					end else begin
						a_q     <= a_p1;
						state_q <= S_ANCH;
					end
				end
				S_ADUP_EV: begin
					a_q     <= a_p1;
					state_q <= (rd0_q == aval_q) ? S_ADUP : S_ANCH;
				end
				S_FIN: begin
					if (ofree) begin
						out_v_q <= 1'b1;
						if (pend_v_q) begin
							out_q <= pend_q;
						end else begin
							out_q <= '0;
						end
						out_q.last_result    <= 1'b1;
						out_q.truncated      <= 1'b0;
						out_q.inputs_dropped <= ovf_q;
						cnt_q                <= '0;
						ovf_q                <= 1'b0;
						pend_v_q             <= 1'b0;
						rcnt_q               <= '0;
						state_q              <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY)) else $error("element count past capacity");
	a_rcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= RES_W'(MAX_RESULTS)) else $error("result count past limit");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ofree && (state_q == S_FIN) |=> (state_q == S_LOAD) && (cnt_q == '0) && !pend_v_q)
		else $error("set not cleared after last result");
	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q == (rcnt_q != '0)) else $error("held triple and result count disagree");

endmodule

// ===== rtl/zero_sum_triple_finder.sv =====
// Top level of the zero-sum triple finder: front queue plus search engine.
// Depends on zst_pkg, zst_front and zst_back.
//
//   channel   ports                         carries
//   input     item_valid, item_stall, item  in_item_t: one element of the set
//   output    res_valid, res_stall, res     out_item_t: one triple or the marker
//
// Elements load into the store one per cycle through a four-entry queue while the engine is
// in its load state; otherwise the queue fills and stalls the input. On the final element the
// set is sorted by insertion sort over the store's single write and two read ports, each compare
// a read state then an evaluate state, and the two-pointer search follows in the same manner.
// arst_n clears the queue, the element count and the result logic.
// A stalled output holds its item; the engine waits on it only when it has a new result.
module zero_sum_triple_finder import zst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	q_head_t head;
	logic    pop;

	zst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.head       (head),
		.pop        (pop)
	);

	zst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
